// ----- rtl/hc2d_pkg.sv -----
// Types, constants and mod-26 helper functions for the 2x2 Hill decrypter.
package hc2d_pkg;

   localparam int unsigned LETTER_W = 5;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [LETTER_W-1:0] letter_type;

   // Register indexes as seen in paddr[3:2].
   localparam logic [1:0] REG_TOP_LEFT     = 2'd0;
   localparam logic [1:0] REG_TOP_RIGHT    = 2'd1;
   localparam logic [1:0] REG_BOTTOM_LEFT  = 2'd2;
   localparam logic [1:0] REG_BOTTOM_RIGHT = 2'd3;

   localparam logic [4:0] LETTERS = 5'd26;

   typedef struct packed {
      letter_type top_left;
      letter_type top_right;
      letter_type bottom_left;
      letter_type bottom_right;
   } key_type;

   // Folds a raw 5-bit code (0..31) into 0..25.
   function automatic letter_type reduce_letter(input letter_type v);
      return (v >= LETTERS) ? letter_type'(v - LETTERS) : v;
   endfunction

   // Remainder by 26 of an 11-bit value. The quotient estimate
   // (v * 315) >> 13 is never high and at most one low, so a single
   // conditional subtract finishes the job.
   function automatic letter_type mod26(input logic [10:0] v);
      logic [19:0] prod;
      logic [10:0] q;
      logic [10:0] r;
      prod = 20'(v) * 20'd315;
      q    = {4'b0, prod[19:13]};
      r    = v - 11'(q * 11'd26);
      if (r >= 11'd26) begin
         r = r - 11'd26;
      end
      return r[4:0];
   endfunction

   // Multiplicative inverse modulo 26, or zero when there is none.
   function automatic letter_type inv26(input letter_type v);
      letter_type r;
      unique case (v)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // Additive inverse modulo 26 of a value already in 0..25.
   function automatic letter_type neg26(input letter_type v);
      return (v == 5'd0) ? 5'd0 : letter_type'(LETTERS - v);
   endfunction

endpackage

// ----- rtl/hc2d_core.sv -----
// Seven-stage decryption pipeline: determinant, inverse key and matrix product mod 26.
module hc2d_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  hc2d_pkg::letter_type in_first,
   input  hc2d_pkg::letter_type in_second,
   input  hc2d_pkg::key_type    key,
   output logic                out_valid,
   output hc2d_pkg::letter_type out_first,
   output hc2d_pkg::letter_type out_second,
   output logic                out_invalid
);
   import hc2d_pkg::*;

   // Stage 1: reduced operands and determinant products.
   logic       s1_valid_ff, s1_valid_in;
   letter_type s1_x_ff, s1_y_ff, s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff;
   letter_type s1_x_in, s1_y_in, s1_a_in, s1_b_in, s1_c_in, s1_d_in;
   logic [9:0] s1_ad_ff, s1_bc_ff, s1_ad_in, s1_bc_in;

   // Stage 2: products reduced.
   logic       s2_valid_ff;
   letter_type s2_x_ff, s2_y_ff, s2_a_ff, s2_b_ff, s2_c_ff, s2_d_ff;
   letter_type s2_ad_ff, s2_bc_ff, s2_ad_in, s2_bc_in;

   // Stage 3: determinant inverse and negated off-diagonals.
   logic       s3_valid_ff;
   letter_type s3_x_ff, s3_y_ff, s3_a_ff, s3_d_ff, s3_nb_ff, s3_nc_ff, s3_inv_ff;
   letter_type s3_nb_in, s3_nc_in, s3_inv_in, s3_det;
   logic [5:0] s3_diff;

   // Stage 4: unreduced inverse-key products.
   logic       s4_valid_ff, s4_bad_ff;
   letter_type s4_x_ff, s4_y_ff;
   logic [9:0] s4_p00_ff, s4_p01_ff, s4_p10_ff, s4_p11_ff;

   // Stage 5: inverse key entries.
   logic       s5_valid_ff, s5_bad_ff;
   letter_type s5_x_ff, s5_y_ff, s5_m00_ff, s5_m01_ff, s5_m10_ff, s5_m11_ff;

   // Stage 6: unreduced dot products.
   logic        s6_valid_ff, s6_bad_ff;
   logic [10:0] s6_sum0_ff, s6_sum1_ff, s6_sum0_in, s6_sum1_in;

   // Output register.
   logic       out_valid_ff, out_invalid_ff;
   letter_type out_first_ff, out_second_ff, out_first_in, out_second_in;

   assign s1_valid_in = in_valid;
   assign s1_x_in  = reduce_letter(in_first);
   assign s1_y_in  = reduce_letter(in_second);
   assign s1_a_in  = reduce_letter(key.top_left);
   assign s1_b_in  = reduce_letter(key.top_right);
   assign s1_c_in  = reduce_letter(key.bottom_left);
   assign s1_d_in  = reduce_letter(key.bottom_right);
   assign s1_ad_in = 10'(s1_a_in) * 10'(s1_d_in);
   assign s1_bc_in = 10'(s1_b_in) * 10'(s1_c_in);

   assign s2_ad_in = mod26({1'b0, s1_ad_ff});
   assign s2_bc_in = mod26({1'b0, s1_bc_ff});

   always_comb begin
      s3_diff = 6'(s2_ad_ff) - 6'(s2_bc_ff);
      if (s2_ad_ff < s2_bc_ff) begin
         s3_diff = s3_diff + 6'(LETTERS);
      end
      s3_det = s3_diff[4:0];
   end
   assign s3_inv_in = inv26(s3_det);
   assign s3_nb_in  = neg26(s2_b_ff);
   assign s3_nc_in  = neg26(s2_c_ff);

   assign s6_sum0_in = 11'(10'(s5_m00_ff) * 10'(s5_x_ff)) + 11'(10'(s5_m01_ff) * 10'(s5_y_ff));
   assign s6_sum1_in = 11'(10'(s5_m10_ff) * 10'(s5_x_ff)) + 11'(10'(s5_m11_ff) * 10'(s5_y_ff));

   // An invalid key forces both letters to zero.
   assign out_first_in  = s6_bad_ff ? 5'd0 : mod26(s6_sum0_ff);
   assign out_second_in = s6_bad_ff ? 5'd0 : mod26(s6_sum1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         out_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff  <= s1_x_in;
      s1_y_ff  <= s1_y_in;
      s1_a_ff  <= s1_a_in;
      s1_b_ff  <= s1_b_in;
      s1_c_ff  <= s1_c_in;
      s1_d_ff  <= s1_d_in;
      s1_ad_ff <= s1_ad_in;
      s1_bc_ff <= s1_bc_in;

      s2_x_ff  <= s1_x_ff;
      s2_y_ff  <= s1_y_ff;
      s2_a_ff  <= s1_a_ff;
      s2_b_ff  <= s1_b_ff;
      s2_c_ff  <= s1_c_ff;
      s2_d_ff  <= s1_d_ff;
      s2_ad_ff <= s2_ad_in;
      s2_bc_ff <= s2_bc_in;

      s3_x_ff   <= s2_x_ff;
      s3_y_ff   <= s2_y_ff;
      s3_a_ff   <= s2_a_ff;
      s3_d_ff   <= s2_d_ff;
      s3_nb_ff  <= s3_nb_in;
      s3_nc_ff  <= s3_nc_in;
      s3_inv_ff <= s3_inv_in;

      s4_x_ff   <= s3_x_ff;
      s4_y_ff   <= s3_y_ff;
      s4_bad_ff <= (s3_inv_ff == 5'd0);
      s4_p00_ff <= 10'(s3_d_ff) * 10'(s3_inv_ff);
      s4_p01_ff <= 10'(s3_nb_ff) * 10'(s3_inv_ff);
      s4_p10_ff <= 10'(s3_nc_ff) * 10'(s3_inv_ff);
      s4_p11_ff <= 10'(s3_a_ff) * 10'(s3_inv_ff);

      s5_x_ff   <= s4_x_ff;
      s5_y_ff   <= s4_y_ff;
      s5_bad_ff <= s4_bad_ff;
      s5_m00_ff <= mod26({1'b0, s4_p00_ff});
      s5_m01_ff <= mod26({1'b0, s4_p01_ff});
      s5_m10_ff <= mod26({1'b0, s4_p10_ff});
      s5_m11_ff <= mod26({1'b0, s4_p11_ff});

      s6_bad_ff  <= s5_bad_ff;
      s6_sum0_ff <= s6_sum0_in;
      s6_sum1_ff <= s6_sum1_in;

      out_invalid_ff <= s6_bad_ff;
      out_first_ff   <= out_first_in;
      out_second_ff  <= out_second_in;
   end

   assign out_valid   = out_valid_ff;
   assign out_first   = out_first_ff;
   assign out_second  = out_second_ff;
   assign out_invalid = out_invalid_ff;

endmodule

// ----- rtl/hill_cipher_2x2_decrypt_top.sv -----
// Top level of the 2x2 Hill cipher decrypter: key registers, APB port and pipeline.
//
// This block decrypts pairs of ciphertext letters (A=0 .. Z=25) with a 2x2 Hill key held in
// four registers on the APB port (top left, top right, bottom left, bottom right at byte
// addresses 0, 4, 8 and 12; reset loads the identity key). A word is taken whenever start
// is high and busy is low. busy never rises, so a new pair can be taken in every cycle.
// Each pair produces exactly one result word, registered at the end of the pipeline, shown for a
// single cycle with rsp_valid high; the receiver cannot stall, and results leave in the
// order the pairs arrived. The pipeline registers hold, in order: operand reduction and
// determinant products, their reduction mod 26, the modular inverse of the determinant,
// the inverse-key products, their reduction, the letter dot products, and the final
// reduction into the output register. Letter or key codes 26..31 are folded mod 26.
// When the key determinant has no inverse mod 26, rsp_key_invalid is set and both letters
// are zero. Write the key only while no pairs are in flight.
module hill_cipher_2x2_decrypt_top (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              start,
   output logic                              busy,
   input  hc2d_pkg::letter_type              req_first_letter,
   input  hc2d_pkg::letter_type              req_second_letter,

   output logic                              rsp_valid,
   output hc2d_pkg::letter_type              rsp_first_plain,
   output hc2d_pkg::letter_type              rsp_second_plain,
   output logic                              rsp_key_invalid,

   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hc2d_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hc2d_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hc2d_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import hc2d_pkg::*;

   key_type    key_ff;
   key_type    key_in;
   logic       csr_write;
   logic [1:0] csr_index;
   letter_type csr_value;
   letter_type csr_read_value;
   logic       accept;

   // The pipeline never stalls, so the block is always ready.
   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign pready = 1'b1;

   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[3:2];
   assign csr_value = pwdata[LETTER_W-1:0];

   // Key register update; only the low five bits of the data are kept.
   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_TOP_LEFT:     key_in.top_left     = csr_value;
            REG_TOP_RIGHT:    key_in.top_right    = csr_value;
            REG_BOTTOM_LEFT:  key_in.bottom_left  = csr_value;
            REG_BOTTOM_RIGHT: key_in.bottom_right = csr_value;
            default:          key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.top_left     <= 5'd1;
         key_ff.top_right    <= 5'd0;
         key_ff.bottom_left  <= 5'd0;
         key_ff.bottom_right <= 5'd1;
      end else begin
         key_ff <= key_in;
      end
   end

   // Read data is a plain mux of the key registers.
   always_comb begin
      unique case (csr_index)
         REG_TOP_LEFT:     csr_read_value = key_ff.top_left;
         REG_TOP_RIGHT:    csr_read_value = key_ff.top_right;
         REG_BOTTOM_LEFT:  csr_read_value = key_ff.bottom_left;
         REG_BOTTOM_RIGHT: csr_read_value = key_ff.bottom_right;
         default:          csr_read_value = 5'd0;
      endcase
   end
   assign prdata = CSR_DATA_W'(csr_read_value);

   hc2d_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_first    (req_first_letter),
      .in_second   (req_second_letter),
      .key         (key_ff),
      .out_valid   (rsp_valid),
      .out_first   (rsp_first_plain),
      .out_second  (rsp_second_plain),
      .out_invalid (rsp_key_invalid)
   );

endmodule
